[hdl/lss_pkg.sv]
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the limited-service grant scheduler.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int UNIT_W     = 6;
  localparam int OCC_W      = 24;
  localparam int TIME_W     = 32;
  localparam int GUARD_W    = 16;
  localparam int ACT_W      = 7;
  localparam int CNT_W      = 7;
  localparam int REQ_W      = 2;
  localparam int SUM_W      = OCC_W + 1;
  localparam int PROD_W     = 2 * OCC_W;
  localparam int DIV_STEPS  = OCC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int APB_W      = 32;
  localparam int PADDR_W    = 4;

  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RANGE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_GUARD  = 2'd1;
  localparam logic [1:0] REG_MAXG   = 2'd2;

  localparam logic [ACT_W-1:0]   ACTIVE_RST = 7'd16;
  localparam logic [GUARD_W-1:0] GUARD_RST  = 16'd64;
  localparam logic [OCC_W-1:0]   MAXG_RST   = 24'd100000;
  localparam logic [CNT_W-1:0]   CNT_SAT    = 7'd127;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/lss_ram.sv]
// ----------------------------------------------------------------------------
// lss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/lss_div.sv]
// ----------------------------------------------------------------------------
// lss_div
// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor, so the quotient fits in one half.
// ----------------------------------------------------------------------------
module lss_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lss_pkg::PROD_W-1:0]   dividend,
  input  logic [lss_pkg::SUM_W-1:0]    divisor,
  output logic [lss_pkg::OCC_W-1:0]    quotient,
  output logic [lss_pkg::SUM_W-1:0]    remainder,
  output lss_pkg::div_stat_t           stat
);

  logic                           run_r;
  logic                           done_r;
  logic [lss_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [lss_pkg::SUM_W-1:0]      rem_r;
  logic [lss_pkg::OCC_W-1:0]      quo_r;
  logic [lss_pkg::SUM_W-1:0]      dsr_r;
  logic [lss_pkg::SUM_W:0]        shifted;
  logic [lss_pkg::SUM_W+1:0]      trial;
  logic                           qbit;

  assign shifted = {rem_r, quo_r[lss_pkg::OCC_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};
  assign qbit    = ~trial[lss_pkg::SUM_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == lss_pkg::DIV_CNT_W'(lss_pkg::DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[lss_pkg::PROD_W-1:lss_pkg::OCC_W]};
      quo_r <= dividend[lss_pkg::OCC_W-1:0];
      dsr_r <= divisor;
    end else if (run_r) begin
      rem_r <= qbit ? trial[lss_pkg::SUM_W-1:0] : shifted[lss_pkg::SUM_W-1:0];
      quo_r <= {quo_r[lss_pkg::OCC_W-2:0], qbit};
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

[hdl/pon_limited_service_grant_scheduler.sv]
// ----------------------------------------------------------------------------
// pon_limited_service_grant_scheduler
// Upstream bandwidth-map builder with limited-service grants.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Request types:
// occupancy report, ranging reply, cycle tick.
// Report: the slot is unit_index modulo the unit count, found on the shared
//   divider.
// Ranging reply: stored in the accept cycle; when the reply count reaches
//   the unit count, a preset sweep writes one class-3 entry per cycle.
// Tick: one map entry per unit on out_valid, last one flagged by
//   out_last_entry. Each unit goes through a RAM read, a load, and per
//   class one multiply plus a 24-step division on the shared divider, then
//   the emit state.
// Results are shown for one cycle only; the receiver cannot stall them.
// Reset clears the stores through valid bits, the counters and the
// registers (active 16, guard 64, max grant 100000). No clearing pass.
// Configuration over APB at byte addresses 0, 4, 8; pready is tied high.
// ----------------------------------------------------------------------------
module pon_limited_service_grant_scheduler #(
  parameter int MAX_UNITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lss_pkg::REQ_W-1:0]     in_req_type,
  input  logic [lss_pkg::UNIT_W-1:0]    in_unit_index,
  input  logic [lss_pkg::OCC_W-1:0]     in_occupancy_class2,
  input  logic [lss_pkg::OCC_W-1:0]     in_occupancy_class3,
  input  logic [lss_pkg::TIME_W-1:0]    in_round_trip,
  output logic                          out_valid,
  output logic [lss_pkg::UNIT_W-1:0]    out_unit,
  output logic [lss_pkg::OCC_W-1:0]     out_grant_class2,
  output logic [lss_pkg::TIME_W-1:0]    out_start_class2,
  output logic [lss_pkg::OCC_W-1:0]     out_grant_class3,
  output logic [lss_pkg::TIME_W-1:0]    out_start_class3,
  output logic [lss_pkg::TIME_W-1:0]    out_unit_round_trip,
  output logic [lss_pkg::TIME_W-1:0]    out_cycle_number,
  output logic                          out_last_entry,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lss_pkg::PADDR_W-1:0]   paddr,
  input  logic [lss_pkg::APB_W-1:0]     pwdata,
  output logic [lss_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);

  localparam int AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int NW = $clog2(MAX_UNITS + 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MOD_GO   = 4'd1;
  localparam logic [3:0] ST_MOD_WAIT = 4'd2;
  localparam logic [3:0] ST_PRESET   = 4'd3;
  localparam logic [3:0] ST_READ     = 4'd4;
  localparam logic [3:0] ST_LOAD     = 4'd5;
  localparam logic [3:0] ST_MUL      = 4'd6;
  localparam logic [3:0] ST_DIV_GO   = 4'd7;
  localparam logic [3:0] ST_DIV_WAIT = 4'd8;
  localparam logic [3:0] ST_EMIT     = 4'd9;

  // configuration
  logic [lss_pkg::ACT_W-1:0]   active_r;
  logic [lss_pkg::GUARD_W-1:0] guard_r;
  logic [lss_pkg::OCC_W-1:0]   maxg_r;
  logic                        cfg_wr;

  // control
  logic [3:0]                  state_r, state_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [lss_pkg::CNT_W-1:0]   rng_cnt_r, rng_cnt_nxt;
  logic [lss_pkg::TIME_W-1:0]  cyc_r, cyc_nxt;
  logic                        phase_r, phase_nxt;
  logic [MAX_UNITS-1:0]        v2_r, v2_nxt;
  logic [MAX_UNITS-1:0]        v3_r, v3_nxt;
  logic [MAX_UNITS-1:0]        vr_r, vr_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // datapath
  logic [lss_pkg::UNIT_W-1:0]  unit_r;
  logic [lss_pkg::OCC_W-1:0]   occ2_r, occ3_r;
  logic [lss_pkg::OCC_W-1:0]   b2_r, b3_r;
  logic [lss_pkg::TIME_W-1:0]  rtt_r;
  logic [lss_pkg::SUM_W-1:0]   sum_r;
  logic [lss_pkg::PROD_W-1:0]  prod_r;
  logic [lss_pkg::OCC_W-1:0]   g2_r, g3_r;
  logic [lss_pkg::TIME_W-1:0]  cursor_r, st2_r, st3_r;
  logic [lss_pkg::OCC_W-1:0]   mul_op;
  logic [lss_pkg::OCC_W-1:0]   cur_b;
  logic [lss_pkg::OCC_W-1:0]   grant;

  logic [NW-1:0]               n_units;
  logic                        accept;
  logic                        last_idx;
  logic [lss_pkg::CNT_W-1:0]   cnt_inc;

  // divider
  logic                        div_start;
  logic [lss_pkg::PROD_W-1:0]  div_dividend;
  logic [lss_pkg::SUM_W-1:0]   div_divisor;
  logic [lss_pkg::OCC_W-1:0]   div_quo;
  logic [lss_pkg::SUM_W-1:0]   div_rem;
  lss_pkg::div_stat_t          div_stat;

  // RAMs
  logic                        c2_we, c3_we, rt_we;
  logic [AW-1:0]               c3_waddr, rt_waddr, slot;
  logic [lss_pkg::OCC_W-1:0]   c3_wdata;
  logic [lss_pkg::OCC_W-1:0]   c2_q, c3_q;
  logic [lss_pkg::TIME_W-1:0]  rt_q;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= lss_pkg::ACTIVE_RST;
      guard_r  <= lss_pkg::GUARD_RST;
      maxg_r   <= lss_pkg::MAXG_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lss_pkg::REG_ACTIVE: active_r <= pwdata[lss_pkg::ACT_W-1:0];
        lss_pkg::REG_GUARD:  guard_r  <= pwdata[lss_pkg::GUARD_W-1:0];
        lss_pkg::REG_MAXG:   maxg_r   <= pwdata[lss_pkg::OCC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lss_pkg::REG_ACTIVE: prdata = lss_pkg::APB_W'(active_r);
      lss_pkg::REG_GUARD:  prdata = lss_pkg::APB_W'(guard_r);
      lss_pkg::REG_MAXG:   prdata = lss_pkg::APB_W'(maxg_r);
      default:             prdata = '0;
    endcase
  end

  assign n_units  = (active_r < lss_pkg::ACT_W'(MAX_UNITS)) ? active_r[NW-1:0]
                                                            : NW'(MAX_UNITS);
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start & ~busy;
  assign last_idx = ((NW + 1)'(idx_r) + 1'b1) == (NW + 1)'(n_units);
  assign cnt_inc  = (rng_cnt_r == lss_pkg::CNT_SAT) ? rng_cnt_r : rng_cnt_r + 1'b1;
  assign slot     = div_rem[AW-1:0];

  // shared divider
  assign div_start    = (state_r == ST_MOD_GO) || (state_r == ST_DIV_GO);
  assign div_dividend = (state_r == ST_MOD_GO) ? lss_pkg::PROD_W'(unit_r) : prod_r;
  assign div_divisor  = (state_r == ST_MOD_GO) ? lss_pkg::SUM_W'(n_units) : sum_r;

  lss_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign c2_we    = (state_r == ST_MOD_WAIT) && div_stat.done;
  assign c3_we    = c2_we || (state_r == ST_PRESET);
  assign c3_waddr = (state_r == ST_PRESET) ? idx_r : slot;
  assign c3_wdata = (state_r == ST_PRESET) ? maxg_r : occ3_r;
  assign rt_we    = accept && (in_req_type == lss_pkg::REQ_RANGE) &&
                    ({1'b0, in_unit_index} < lss_pkg::ACT_W'(MAX_UNITS));
  assign rt_waddr = in_unit_index[AW-1:0];

  lss_ram #(.WIDTH(lss_pkg::OCC_W), .DEPTH(MAX_UNITS)) u_c2_ram (
    .clk (clk), .we (c2_we), .waddr (slot), .wdata (occ2_r),
    .raddr (idx_r), .rdata (c2_q)
  );

  lss_ram #(.WIDTH(lss_pkg::OCC_W), .DEPTH(MAX_UNITS)) u_c3_ram (
    .clk (clk), .we (c3_we), .waddr (c3_waddr), .wdata (c3_wdata),
    .raddr (idx_r), .rdata (c3_q)
  );

  lss_ram #(.WIDTH(lss_pkg::TIME_W), .DEPTH(MAX_UNITS)) u_rt_ram (
    .clk (clk), .we (rt_we), .waddr (rt_waddr), .wdata (in_round_trip),
    .raddr (idx_r), .rdata (rt_q)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rng_cnt_nxt   = rng_cnt_r;
    cyc_nxt       = cyc_r;
    phase_nxt     = phase_r;
    v2_nxt        = v2_r;
    v3_nxt        = v3_r;
    vr_nxt        = vr_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            lss_pkg::REQ_REPORT: begin
              if (n_units != '0) begin
                state_nxt = ST_MOD_GO;
              end
            end
            lss_pkg::REQ_RANGE: begin
              if (rt_we) begin
                vr_nxt[rt_waddr] = 1'b1;
              end
              rng_cnt_nxt = cnt_inc;
              if (cnt_inc == lss_pkg::CNT_W'(n_units)) begin
                idx_nxt   = '0;
                state_nxt = ST_PRESET;
              end
            end
            lss_pkg::REQ_TICK: begin
              cyc_nxt = cyc_r + 1'b1;
              if (n_units != '0) begin
                idx_nxt   = '0;
                state_nxt = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOD_GO:   state_nxt = ST_MOD_WAIT;
      ST_MOD_WAIT: begin
        if (div_stat.done) begin
          v2_nxt[slot] = 1'b1;
          v3_nxt[slot] = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_PRESET: begin
        v3_nxt[idx_r] = 1'b1;
        if (last_idx) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: begin
        phase_nxt = 1'b0;
        state_nxt = ST_MUL;
      end
      ST_MUL:    state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          phase_nxt = 1'b1;
          state_nxt = phase_r ? ST_EMIT : ST_MUL;
        end
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        if (last_idx) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      rng_cnt_r   <= '0;
      cyc_r       <= '0;
      phase_r     <= 1'b0;
      v2_r        <= '0;
      v3_r        <= '0;
      vr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rng_cnt_r   <= rng_cnt_nxt;
      cyc_r       <= cyc_nxt;
      phase_r     <= phase_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      vr_r        <= vr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  assign mul_op = phase_r ? b3_r : b2_r;
  assign cur_b  = phase_r ? b3_r : b2_r;
  assign grant  = (cur_b < div_quo) ? cur_b : div_quo;

  always_ff @(posedge clk) begin
    if (accept && (in_req_type == lss_pkg::REQ_REPORT)) begin
      unit_r <= in_unit_index;
      occ2_r <= in_occupancy_class2;
      occ3_r <= in_occupancy_class3;
    end
    if (accept && (in_req_type == lss_pkg::REQ_TICK)) begin
      cursor_r <= '0;
    end
    if (state_r == ST_LOAD) begin
      b2_r  <= v2_r[idx_r] ? c2_q : '0;
      b3_r  <= v3_r[idx_r] ? c3_q : '0;
      rtt_r <= vr_r[idx_r] ? rt_q : '0;
      sum_r <= (v2_r[idx_r] ? {1'b0, c2_q} : '0) + (v3_r[idx_r] ? {1'b0, c3_q} : '0);
      st2_r <= cursor_r + lss_pkg::TIME_W'(guard_r);
    end
    if (state_r == ST_MUL) begin
      prod_r <= lss_pkg::PROD_W'(mul_op) * lss_pkg::PROD_W'(maxg_r);
    end
    if ((state_r == ST_DIV_WAIT) && div_stat.done) begin
      if (phase_r) begin
        g3_r <= grant;
      end else begin
        g2_r  <= grant;
        st3_r <= st2_r + lss_pkg::TIME_W'(grant);
      end
    end
    if (state_r == ST_EMIT) begin
      cursor_r            <= st3_r + lss_pkg::TIME_W'(g3_r);
      out_unit            <= lss_pkg::UNIT_W'(idx_r);
      out_grant_class2    <= g2_r;
      out_start_class2    <= st2_r;
      out_grant_class3    <= g3_r;
      out_start_class3    <= st3_r;
      out_unit_round_trip <= rtt_r;
      out_cycle_number    <= cyc_r;
      out_last_entry      <= last_idx;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("map entries on consecutive cycles");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_entry) |-> !busy)
    else $error("still busy after last map entry");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_entry) |-> busy)
    else $error("idle in the middle of a map");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |->
      (state_r == ST_MOD_WAIT || state_r == ST_DIV_WAIT))
    else $error("divider active outside a wait state");

endmodule
